// ===== sv/dcmg_pkg.sv =====
package dcmg_pkg;

   localparam int GAIN_WIDTH   = 16;
   localparam int OFFSET_WIDTH = 32;
   localparam int CUR_WIDTH    = 34;
   localparam int ADC_WIDTH    = 16;
   localparam int OUT_POS_WIDTH = 32;
   localparam int CSR_IDX_WIDTH = 2;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_FWD  = 2'd1,
      MODE_REV  = 2'd2,
      MODE_ERR  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_CMD    = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_TICK   = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   localparam logic [1:0] ACT_FWD = 2'd0;
   localparam logic [1:0] ACT_REV = 2'd1;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GAIN     = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_OFFSET   = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_OC_LIMIT = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LO_LIMIT = 2'd3;

   // trips happen on the sample after the count reaches these
   localparam logic [1:0] OC_TRIP_COUNT  = 2'd2;
   localparam logic [1:0] LOW_TRIP_COUNT = 2'd3;

   localparam logic [GAIN_WIDTH-1:0]         GAIN_RESET     = 16'd4096;
   localparam logic signed [CUR_WIDTH-1:0]   OC_LIMIT_RESET = 34'sh1_FFFF_FFFF;

   typedef struct packed {
      logic over;
      logic under;
   } sense_flags_type;

endpackage

// ===== sv/dcmg_sense.sv =====
module dcmg_sense (
   input  logic [dcmg_pkg::ADC_WIDTH-1:0]           adc,
   input  logic [dcmg_pkg::GAIN_WIDTH-1:0]          gain,
   input  logic signed [dcmg_pkg::OFFSET_WIDTH-1:0] offset,
   input  logic signed [dcmg_pkg::CUR_WIDTH-1:0]    oc_limit,
   input  logic signed [dcmg_pkg::CUR_WIDTH-1:0]    low_limit,
   output logic signed [dcmg_pkg::CUR_WIDTH-1:0]    current,
   output dcmg_pkg::sense_flags_type                flags
);
   import dcmg_pkg::*;

   logic [ADC_WIDTH+GAIN_WIDTH-1:0] product;

   assign product = adc * gain;
   // product is at most 32 bits unsigned, so 34 signed bits hold the sum
   assign current = $signed(CUR_WIDTH'(product)) + CUR_WIDTH'(offset);

   assign flags.over  = current > oc_limit;
   assign flags.under = current < low_limit;

endmodule

// ===== sv/dc_motor_guard_with_position.sv =====
// a request passes the input register, then the result register, before rsp_valid rises
// throughput: one item per cycle while rsp_ready is high; the scale multiply-add and
// limit compares sit in one stage
// with rsp_ready low one more item is still taken into the input stage, then req_ready drops
// reset (synchronous, active high): mode idle, counters, current and position zero,
// registers back to gain 4096, offset 0, overcurrent limit max, low-current limit 0
module dc_motor_guard_with_position #(
   parameter int POSITION_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [1:0]                              req_kind,
   input  logic [1:0]                              req_action,
   input  logic [dcmg_pkg::ADC_WIDTH-1:0]          req_adc_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [1:0]                              rsp_motor_status,
   output logic                                    rsp_drive_forward,
   output logic                                    rsp_drive_reverse,
   output logic signed [dcmg_pkg::CUR_WIDTH-1:0]   rsp_measured_current,
   output logic signed [dcmg_pkg::OUT_POS_WIDTH-1:0] rsp_position,
   input  logic                                    csr_we,
   input  logic [dcmg_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [dcmg_pkg::CUR_WIDTH-1:0]          csr_wdata
);
   import dcmg_pkg::*;

   localparam int EXT_WIDTH = (POSITION_WIDTH > OUT_POS_WIDTH) ? POSITION_WIDTH : OUT_POS_WIDTH;

   // configuration registers
   logic [GAIN_WIDTH-1:0]          gain_ff;
   logic signed [OFFSET_WIDTH-1:0] offset_ff;
   logic signed [CUR_WIDTH-1:0]    oc_limit_ff;
   logic signed [CUR_WIDTH-1:0]    low_limit_ff;

   // input stage
   logic                 in_valid_ff;
   kind_type             kind_ff;
   logic [1:0]           action_ff;
   logic [ADC_WIDTH-1:0] adc_ff;

   // guard state, also the result payload
   logic                          out_valid_ff;
   mode_type                      mode_ff, mode_in;
   logic [1:0]                    oc_count_ff, oc_count_in;
   logic [1:0]                    low_count_ff, low_count_in;
   logic signed [CUR_WIDTH-1:0]   current_ff, current_in;
   logic [POSITION_WIDTH-1:0]     pos_ff, pos_in;

   logic signed [CUR_WIDTH-1:0]   sense_current;
   sense_flags_type               sense_flags;
   logic                          advance;
   logic signed [EXT_WIDTH-1:0]   pos_ext;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RESET;
         offset_ff    <= '0;
         oc_limit_ff  <= OC_LIMIT_RESET;
         low_limit_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN:     gain_ff      <= csr_wdata[GAIN_WIDTH-1:0];
            CSR_OFFSET:   offset_ff    <= $signed(csr_wdata[OFFSET_WIDTH-1:0]);
            CSR_OC_LIMIT: oc_limit_ff  <= $signed(csr_wdata);
            CSR_LO_LIMIT: low_limit_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff   <= kind_type'(req_kind);
         action_ff <= req_action;
         adc_ff    <= req_adc_sample;
      end
   end

   dcmg_sense u_sense (
      .adc       (adc_ff),
      .gain      (gain_ff),
      .offset    (offset_ff),
      .oc_limit  (oc_limit_ff),
      .low_limit (low_limit_ff),
      .current   (sense_current),
      .flags     (sense_flags)
   );

   always_comb begin
      mode_in      = mode_ff;
      oc_count_in  = oc_count_ff;
      low_count_in = low_count_ff;
      current_in   = current_ff;
      pos_in       = pos_ff;
      unique case (kind_ff)
         KIND_CMD: begin
            unique case (action_ff)
               ACT_FWD: begin
                  mode_in      = MODE_FWD;
                  low_count_in = '0;
               end
               ACT_REV: begin
                  mode_in      = MODE_REV;
                  low_count_in = '0;
               end
               default: mode_in = MODE_IDLE;
            endcase
         end
         KIND_SAMPLE: begin
            current_in = sense_current;
            priority if (sense_flags.over) begin
               if (oc_count_ff < OC_TRIP_COUNT) begin
                  oc_count_in = oc_count_ff + 2'd1;
               end else begin
                  oc_count_in = '0;
                  mode_in     = MODE_ERR;
               end
            end else if (sense_flags.under) begin
               if (low_count_ff < LOW_TRIP_COUNT) begin
                  low_count_in = low_count_ff + 2'd1;
               end else begin
                  low_count_in = '0;
                  // limit stop only acts on a running motor
                  if (mode_ff == MODE_FWD || mode_ff == MODE_REV) begin
                     mode_in = MODE_IDLE;
                  end
               end
            end
         end
         KIND_TICK: begin
            if (mode_ff == MODE_FWD) begin
               pos_in = pos_ff + POSITION_WIDTH'(1);
            end else if (mode_ff == MODE_REV) begin
               pos_in = pos_ff - POSITION_WIDTH'(1);
            end
         end
         KIND_CLEAR: pos_in = '0;
         default: ;
      endcase
   end

   // state only moves when a result is loaded, so it doubles as the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_IDLE;
         oc_count_ff  <= '0;
         low_count_ff <= '0;
         current_ff   <= '0;
         pos_ff       <= '0;
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
            mode_ff      <= mode_in;
            oc_count_ff  <= oc_count_in;
            low_count_ff <= low_count_in;
            current_ff   <= current_in;
            pos_ff       <= pos_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign pos_ext = EXT_WIDTH'($signed(pos_ff));

   assign rsp_valid            = out_valid_ff;
   assign rsp_motor_status     = mode_ff;
   assign rsp_drive_forward    = mode_ff == MODE_FWD;
   assign rsp_drive_reverse    = mode_ff == MODE_REV;
   assign rsp_measured_current = current_ff;
   assign rsp_position         = pos_ext[OUT_POS_WIDTH-1:0];

endmodule
